>>> src/max_heap_priority_queue_unit_macros.svh
// ----------------------------------------------------------------------------
// Heap priority queue assertion macros
// Shorthand for clocked assertions on i_clk with i_rst_n low as disable.
// ----------------------------------------------------------------------------
`ifndef MAX_HEAP_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define MAX_HEAP_PRIORITY_QUEUE_UNIT_MACROS_SVH

// same-cycle implication
`define MHPQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define MHPQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> src/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// Heap priority queue package
// Beat types, operation and status codes shared by the queue modules.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    localparam int KEY_W       = 32;
    localparam int ENTRY_W     = 5;
    localparam int QUEUE_DEPTH = 2;   // power of two, pointers wrap naturally
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic KIND_INSERT  = 1'b0;
    localparam logic KIND_EXTRACT = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // classified operation handed from front to back
    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_EXTRACT = 2'd1,
        OP_FULL    = 2'd2,
        OP_EMPTY   = 2'd3
    } t_op;

    typedef struct packed {
        logic                    kind;
        logic signed [KEY_W-1:0] key_in;
    } t_in;

    typedef struct packed {
        logic signed [KEY_W-1:0] key_out;
        t_status                 status;
        logic signed [KEY_W-1:0] top_key;
        logic [ENTRY_W-1:0]      entry_count;
    } t_out;

    typedef struct packed {
        t_op                     op;
        logic signed [KEY_W-1:0] key;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

>>> src/mhpq_front.sv
// ----------------------------------------------------------------------------
// Heap priority queue front end
// Accepts command beats and classifies them against a projected key count.
// ----------------------------------------------------------------------------
module mhpq_front #(
    parameter int CAPACITY = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  mhpq_pkg::t_in    i_cmd,
    input  mhpq_pkg::t_q_stat i_q_stat,
    output logic             busy,
    output logic             o_push,
    output mhpq_pkg::t_cmd   o_push_cmd
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0] r_proj_count;
    logic [CW-1:0] n_proj_count;
    logic          accept;

    assign busy   = i_q_stat.full;
    assign accept = start && !i_q_stat.full;
    assign o_push = accept;

    // classify beat and track the count the back end will reach
    always_comb begin
        n_proj_count   = r_proj_count;
        o_push_cmd.key = i_cmd.key_in;
        o_push_cmd.op  = mhpq_pkg::OP_INSERT;
        if (i_cmd.kind == mhpq_pkg::KIND_INSERT) begin
            if (r_proj_count == CW'(CAPACITY)) begin
                o_push_cmd.op = mhpq_pkg::OP_FULL;
            end else begin
                o_push_cmd.op = mhpq_pkg::OP_INSERT;
                if (accept) n_proj_count = r_proj_count + CW'(1);
            end
        end else begin
            if (r_proj_count == '0) begin
                o_push_cmd.op = mhpq_pkg::OP_EMPTY;
            end else begin
                o_push_cmd.op = mhpq_pkg::OP_EXTRACT;
                if (accept) n_proj_count = r_proj_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_proj_count <= '0;
        end else begin
            r_proj_count <= n_proj_count;
        end
    end

endmodule

>>> src/mhpq_cmd_fifo.sv
// ----------------------------------------------------------------------------
// Heap priority queue command queue
// Short queue of classified commands between front and back end.
// ----------------------------------------------------------------------------
module mhpq_cmd_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mhpq_pkg::t_cmd    i_push_cmd,
    input  logic              i_pop,
    output mhpq_pkg::t_cmd    o_head,
    output mhpq_pkg::t_q_stat o_stat
);

    mhpq_pkg::t_cmd                  r_mem [mhpq_pkg::QUEUE_DEPTH];
    logic [mhpq_pkg::QUEUE_AW-1:0]   r_wr_ptr;
    logic [mhpq_pkg::QUEUE_AW-1:0]   r_rd_ptr;
    logic [mhpq_pkg::QUEUE_CW-1:0]   r_cnt;
    logic                            do_push;
    logic                            do_pop;

    assign o_stat.full  = (r_cnt == mhpq_pkg::QUEUE_CW'(mhpq_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_push_cmd;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + mhpq_pkg::QUEUE_AW'(1);
            if (do_pop)  r_rd_ptr <= r_rd_ptr + mhpq_pkg::QUEUE_AW'(1);
            priority if (do_push && !do_pop) begin
                r_cnt <= r_cnt + mhpq_pkg::QUEUE_CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - mhpq_pkg::QUEUE_CW'(1);
            end
        end
    end

endmodule

>>> src/mhpq_back.sv
// ----------------------------------------------------------------------------
// Heap priority queue back end
// Executes commands on the heap memory with a hole-based sift unit.
// ----------------------------------------------------------------------------
module mhpq_back #(
    parameter int CAPACITY = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mhpq_pkg::t_cmd    i_head,
    input  mhpq_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    output logic              o_strobe,
    output mhpq_pkg::t_out    o_result
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = mhpq_pkg::KEY_W;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_UP_CMP = 5'b00010,
        S_UP_WR0 = 5'b00100,
        S_EXT_LD = 5'b01000,
        S_DN_CMP = 5'b10000
    } t_state;

    // heap memory and registered read ports
    logic signed [KW-1:0] r_mem [CAPACITY];
    logic signed [KW-1:0] r_rd_a;
    logic signed [KW-1:0] r_rd_b;

    t_state               r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [IW-1:0]        r_pos, n_pos;
    logic signed [KW-1:0] r_key, n_key;
    logic signed [KW-1:0] r_root, n_root;
    logic signed [KW-1:0] r_extracted, n_extracted;
    logic                 r_out_valid, n_out_valid;
    mhpq_pkg::t_out       r_out, n_out;

    logic                 we;
    logic [IW-1:0]        waddr;
    logic signed [KW-1:0] wdata;
    logic [IW-1:0]        raddr_a;
    logic [IW-1:0]        raddr_b;

    logic                 finish;
    mhpq_pkg::t_status    fin_status;
    logic signed [KW-1:0] fin_key_out;

    // sift-down selection
    logic [IW:0]          lc, rc, best_idx;
    logic                 lc_ok, rc_ok, moved;
    logic signed [KW-1:0] best_val;
    logic [IW-1:0]        up_par;

    function automatic logic [IW-1:0] parent_of(input logic [IW-1:0] p);
        logic [IW-1:0] m;
        m = p - IW'(1);
        return m >> 1;
    endfunction

    function automatic logic [IW:0] left_of(input logic [IW-1:0] p);
        return {p, 1'b1};
    endfunction

    assign o_strobe = r_out_valid;
    assign o_result = r_out;
    assign up_par   = parent_of(r_pos);

    // children of current hole, pick largest that beats the moving key
    always_comb begin
        lc       = left_of(r_pos);
        rc       = lc + (IW + 1)'(1);
        lc_ok    = lc < (IW + 1)'(r_count);
        rc_ok    = rc < (IW + 1)'(r_count);
        best_idx = {1'b0, r_pos};
        best_val = r_key;
        moved    = 1'b0;
        if (lc_ok && (r_rd_a > best_val)) begin
            best_idx = lc;
            best_val = r_rd_a;
            moved    = 1'b1;
        end
        if (rc_ok && (r_rd_b > best_val)) begin
            best_idx = rc;
            best_val = r_rd_b;
            moved    = 1'b1;
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_key       = r_key;
        n_extracted = r_extracted;
        we          = 1'b0;
        waddr       = '0;
        wdata       = r_key;
        raddr_a     = '0;
        raddr_b     = '0;
        o_pop       = 1'b0;
        finish      = 1'b0;
        fin_status  = mhpq_pkg::ST_OK;
        fin_key_out = '0;

        unique case (r_state)
            S_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop = 1'b1;
                    unique case (i_head.op)
                        mhpq_pkg::OP_INSERT: begin
                            n_key   = i_head.key;
                            n_pos   = r_count[IW-1:0];
                            n_count = r_count + CW'(1);
                            if (r_count == '0) begin
                                we     = 1'b1;
                                waddr  = '0;
                                wdata  = i_head.key;
                                finish = 1'b1;
                            end else begin
                                raddr_a = parent_of(r_count[IW-1:0]);
                                n_state = S_UP_CMP;
                            end
                        end
                        mhpq_pkg::OP_EXTRACT: begin
                            n_extracted = r_root;
                            n_count     = r_count - CW'(1);
                            raddr_a     = IW'(r_count - CW'(1));
                            n_state     = S_EXT_LD;
                        end
                        mhpq_pkg::OP_FULL: begin
                            finish     = 1'b1;
                            fin_status = mhpq_pkg::ST_FULL;
                        end
                        mhpq_pkg::OP_EMPTY: begin
                            finish     = 1'b1;
                            fin_status = mhpq_pkg::ST_EMPTY;
                        end
                        default: ;
                    endcase
                end
            end
            S_UP_CMP: begin
                we    = 1'b1;
                waddr = r_pos;
                if (r_key > r_rd_a) begin
                    wdata = r_rd_a;
                    n_pos = up_par;
                    if (up_par == '0) begin
                        n_state = S_UP_WR0;
                    end else begin
                        raddr_a = parent_of(up_par);
                    end
                end else begin
                    wdata   = r_key;
                    finish  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_UP_WR0: begin
                we      = 1'b1;
                waddr   = '0;
                wdata   = r_key;
                finish  = 1'b1;
                n_state = S_IDLE;
            end
            S_EXT_LD: begin
                n_key = r_rd_a;
                if (r_count == '0) begin
                    finish      = 1'b1;
                    fin_key_out = r_extracted;
                    n_state     = S_IDLE;
                end else begin
                    n_pos   = '0;
                    raddr_a = IW'(left_of('0));
                    raddr_b = IW'(left_of('0) + (IW + 1)'(1));
                    n_state = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                we    = 1'b1;
                waddr = r_pos;
                if (moved) begin
                    wdata   = best_val;
                    n_pos   = best_idx[IW-1:0];
                    raddr_a = IW'(left_of(best_idx[IW-1:0]));
                    raddr_b = IW'(left_of(best_idx[IW-1:0]) + (IW + 1)'(1));
                end else begin
                    wdata       = r_key;
                    finish      = 1'b1;
                    fin_key_out = r_extracted;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // root mirror and result beat
    always_comb begin
        n_root = (we && (waddr == '0)) ? wdata : r_root;
        n_out_valid         = finish;
        n_out.key_out       = fin_key_out;
        n_out.status        = fin_status;
        n_out.top_key       = (n_count != '0) ? n_root : '0;
        n_out.entry_count   = mhpq_pkg::ENTRY_W'(n_count);
    end

    // heap memory
    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        r_rd_a <= r_mem[raddr_a];
        r_rd_b <= r_mem[raddr_b];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pos       <= n_pos;
        r_key       <= n_key;
        r_root      <= n_root;
        r_extracted <= n_extracted;
        r_out       <= n_out;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> src/max_heap_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// Max-heap priority queue unit
// Bounded priority queue of signed keys with insert and extract-max.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive i_cmd and raise start; a beat is taken on a rising
//   edge with start high and busy low. kind selects insert or extract-max.
//   Result channel: o_strobe is high for one cycle with o_result holding the
//   extracted key, status (ok, full, empty), current top key and key count.
//   The receiver cannot stall; each result is valid for that one cycle only.
// Flow:
//   A refused insert or extract goes through the command queue and the
//   registered result beat, behind any sift in progress. Other commands
//   use the sift unit, one heap level per cycle, on a memory with two
//   registered read ports and one write port.
//   A two-beat command queue lets new beats in while a sift runs; busy
//   rises only when that queue is full.
// Reset:
//   Synchronous active-low reset empties the queue and the heap; the heap
//   memory itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`include "max_heap_priority_queue_unit_macros.svh"

module max_heap_priority_queue_unit #(
    parameter int CAPACITY = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  mhpq_pkg::t_in  i_cmd,
    output logic           busy,
    output logic           o_strobe,
    output mhpq_pkg::t_out o_result
);

    logic              push;
    mhpq_pkg::t_cmd    push_cmd;
    logic              pop;
    mhpq_pkg::t_cmd    head;
    mhpq_pkg::t_q_stat q_stat;

    logic              res_full;
    logic              res_empty;
    logic              full_fields_ok;
    logic              empty_fields_ok;

    mhpq_front #(
        .CAPACITY(CAPACITY)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_cmd      (i_cmd),
        .i_q_stat   (q_stat),
        .busy       (busy),
        .o_push     (push),
        .o_push_cmd (push_cmd)
    );

    mhpq_cmd_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .i_pop      (pop),
        .o_head     (head),
        .o_stat     (q_stat)
    );

    mhpq_back #(
        .CAPACITY(CAPACITY)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // result beat terms for the checks
    assign res_full        = o_strobe && (o_result.status == mhpq_pkg::ST_FULL);
    assign res_empty       = o_strobe && (o_result.status == mhpq_pkg::ST_EMPTY);
    assign full_fields_ok  = (o_result.entry_count == mhpq_pkg::ENTRY_W'(CAPACITY))
                          && (o_result.key_out == '0);
    assign empty_fields_ok = (o_result.entry_count == '0) && (o_result.top_key == '0);

    // checks
    `MHPQ_ASSERT_IMP(a_full_count, res_full, full_fields_ok)
    `MHPQ_ASSERT_IMP(a_empty_zero, res_empty, empty_fields_ok)
    `MHPQ_ASSERT_IMP(a_no_pop_empty, pop, !q_stat.empty)
    `MHPQ_ASSERT_NXT(a_push_fills, push && !pop && q_stat.empty, !q_stat.empty)

endmodule

>>> bench/tb_max_heap_priority_queue_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Max-heap priority queue unit testbench
// Sends insert and extract-max beats and keeps a shadow heap of the keys.
// Each result beat is checked field by field against the outcome that the
// shadow heap gives for the matching command. The bench runs a directed part
// covering empty, full, extreme and tied keys, then bursts of random traffic
// with random sender gaps.
// ----------------------------------------------------------------------------
module tb_max_heap_priority_queue_unit;

    localparam int HEAP_CAP       = 16;
    localparam int RANDOM_BEATS   = 580;
    localparam int MAX_GAP        = 11;
    localparam int SETTLE_CYCLES  = 16;    // extra idle time after the final drain
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat either way
    localparam int REPORT_LIMIT   = 10;

    localparam logic signed [mhpq_pkg::KEY_W-1:0] KEY_MAX =
        {1'b0, {(mhpq_pkg::KEY_W-1){1'b1}}};
    localparam logic signed [mhpq_pkg::KEY_W-1:0] KEY_MIN = ~KEY_MAX;

    logic            i_clk;
    logic            i_rst_n;
    logic            start;
    mhpq_pkg::t_in   i_cmd;
    logic            busy;
    logic            o_strobe;
    mhpq_pkg::t_out  o_result;

    // shadow heap and expected outcomes in beat order
    logic signed [mhpq_pkg::KEY_W-1:0] heap_keys [HEAP_CAP];
    int              heap_size;
    mhpq_pkg::t_out  op_outcomes_due [$];

    bit   back_to_back;
    int   mismatch_count;
    int   idle_cycles;
    int   beats_sent;
    int   inserts_done;
    int   extracts_done;
    int   full_refusals;
    int   empty_refusals;

    max_heap_priority_queue_unit #(
        .CAPACITY (HEAP_CAP)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always #1 i_clk = ~i_clk;

    // apply one command to the shadow heap and return its result beat
    function automatic mhpq_pkg::t_out heap_apply_op(mhpq_pkg::t_in beat);
        mhpq_pkg::t_out                    outcome;
        int                                pos;
        int                                parent;
        int                                best;
        int                                child;
        bit                                settled;
        logic signed [mhpq_pkg::KEY_W-1:0] held_key;
        outcome        = '0;
        outcome.status = mhpq_pkg::ST_OK;
        if (beat.kind == mhpq_pkg::KIND_INSERT) begin
            if (heap_size >= HEAP_CAP) begin
                outcome.status = mhpq_pkg::ST_FULL;
                full_refusals++;
            end else begin
                heap_keys[heap_size] = beat.key_in;
                pos = heap_size;
                heap_size++;
                inserts_done++;
                settled = 1'b0;
                // sift up while strictly greater than the parent
                while (pos > 0 && !settled) begin
                    parent = (pos - 1) / 2;
                    if (heap_keys[pos] > heap_keys[parent]) begin
                        held_key          = heap_keys[pos];
                        heap_keys[pos]    = heap_keys[parent];
                        heap_keys[parent] = held_key;
                        pos               = parent;
                    end else begin
                        settled = 1'b1;
                    end
                end
            end
        end else if (heap_size == 0) begin
            outcome.status = mhpq_pkg::ST_EMPTY;
            empty_refusals++;
        end else begin
            outcome.key_out = heap_keys[0];
            heap_keys[0]    = heap_keys[heap_size-1];
            heap_size--;
            extracts_done++;
            pos     = 0;
            settled = 1'b0;
            // sift down toward the larger child; ties stay put
            while (!settled) begin
                best = pos;
                for (child = 2 * pos + 1; child <= 2 * pos + 2; child++) begin
                    if (child < heap_size && heap_keys[child] > heap_keys[best]) begin
                        best = child;
                    end
                end
                if (best == pos) begin
                    settled = 1'b1;
                end else begin
                    held_key        = heap_keys[pos];
                    heap_keys[pos]  = heap_keys[best];
                    heap_keys[best] = held_key;
                    pos             = best;
                end
            end
        end
        outcome.top_key     = (heap_size > 0) ? heap_keys[0] : '0;
        outcome.entry_count = mhpq_pkg::ENTRY_W'(heap_size);
        return outcome;
    endfunction

    // mostly full-range keys, some extremes, some small values for ties
    function automatic logic signed [mhpq_pkg::KEY_W-1:0] draw_key();
        logic signed [mhpq_pkg::KEY_W-1:0] key;
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 3))
                    0:       key = KEY_MIN;
                    1:       key = KEY_MAX;
                    2:       key = '0;
                    default: key = '1;
                endcase
            end
            1, 2:    key = mhpq_pkg::KEY_W'(int'($urandom_range(0, 6)) - 3);
            default: key = $urandom;
        endcase
        return key;
    endfunction

    // send one command beat; returns at the edge that accepts it
    task automatic send_beat(input logic kind,
                             input logic signed [mhpq_pkg::KEY_W-1:0] key);
        mhpq_pkg::t_in beat;
        int            gap;
        beat.kind   = kind;
        beat.key_in = key;
        gap = back_to_back ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_cmd <= beat;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        op_outcomes_due.push_back(heap_apply_op(beat));
        beats_sent++;
    endtask

    // hold the sender off until every outstanding result is back
    task automatic wait_for_drain();
        start <= 1'b0;
        while (op_outcomes_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string what,
                               input logic [mhpq_pkg::KEY_W-1:0] want,
                               input logic [mhpq_pkg::KEY_W-1:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
                $display("%0t: %s mismatch, expected %0h, got %0h",
                         $time, what, want, got);
            end
        end
    endtask

    // empty extract, extreme keys, equal keys
    task automatic test_empty_and_extremes();
        send_beat(mhpq_pkg::KIND_EXTRACT, '0);
        send_beat(mhpq_pkg::KIND_INSERT, KEY_MIN);
        send_beat(mhpq_pkg::KIND_INSERT, KEY_MAX);
        send_beat(mhpq_pkg::KIND_INSERT, '0);
        send_beat(mhpq_pkg::KIND_INSERT, '1);
        send_beat(mhpq_pkg::KIND_INSERT, 32'sd7);
        send_beat(mhpq_pkg::KIND_INSERT, 32'sd7);
        send_beat(mhpq_pkg::KIND_EXTRACT, KEY_MAX);
        send_beat(mhpq_pkg::KIND_EXTRACT, '1);
    endtask

    // fill to capacity, then one insert that must be dropped
    task automatic test_full_heap();
        while (heap_size < HEAP_CAP) send_beat(mhpq_pkg::KIND_INSERT, draw_key());
        send_beat(mhpq_pkg::KIND_INSERT, KEY_MAX);
    endtask

    // bursts biased toward filling, draining or mixing
    task automatic test_random_traffic();
        int sent;
        int burst_len;
        int insert_pct;
        bit paused;
        sent   = 0;
        paused = 1'b0;
        while (sent < RANDOM_BEATS) begin
            burst_len = $urandom_range(4, 24);
            case ($urandom_range(0, 2))
                0:       insert_pct = 85;
                1:       insert_pct = 15;
                default: insert_pct = 50;
            endcase
            back_to_back = ($urandom_range(0, 3) == 0);
            repeat (burst_len) begin
                if ($urandom_range(1, 100) <= insert_pct) begin
                    send_beat(mhpq_pkg::KIND_INSERT, draw_key());
                end else begin
                    send_beat(mhpq_pkg::KIND_EXTRACT, draw_key());
                end
                sent++;
            end
            if (!paused && sent >= RANDOM_BEATS / 2) begin
                wait_for_drain();
                paused = 1'b1;
            end
        end
        back_to_back = 1'b0;
    endtask

    // result beat checker
    always @(posedge i_clk) begin
        mhpq_pkg::t_out want;
        if (i_rst_n && o_strobe) begin
            if (op_outcomes_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("%0t: result beat with no command outstanding", $time);
                end
            end else begin
                want = op_outcomes_due.pop_front();
                check_field("key_out", want.key_out, o_result.key_out);
                check_field("status", mhpq_pkg::KEY_W'(want.status),
                            mhpq_pkg::KEY_W'(o_result.status));
                check_field("top_key", want.top_key, o_result.top_key);
                check_field("entry_count", mhpq_pkg::KEY_W'(want.entry_count),
                            mhpq_pkg::KEY_W'(o_result.entry_count));
            end
        end
    end

    // watchdog: too long with neither a command nor a result beat
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_strobe) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired after %0d idle cycles", idle_cycles);
                $display("tb_max_heap_priority_queue_unit: FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        i_clk          = 1'b0;
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_cmd          <= '0;
        heap_size      = 0;
        back_to_back   = 1'b0;
        mismatch_count = 0;
        idle_cycles    = 0;
        beats_sent     = 0;
        inserts_done   = 0;
        extracts_done  = 0;
        full_refusals  = 0;
        empty_refusals = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_and_extremes();
        test_full_heap();
        wait_for_drain();
        test_random_traffic();

        // let the last sift finish before judging
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d commands: %0d inserts, %0d extracts,", beats_sent,
                 inserts_done, extracts_done);
        $display("%0d inserts refused on a full heap, %0d extracts on an empty heap.",
                 full_refusals, empty_refusals);
        if (mismatch_count == 0 && op_outcomes_due.size() == 0) begin
            $display("tb_max_heap_priority_queue_unit: PASS");
        end else begin
            $display("tb_max_heap_priority_queue_unit: FAIL");
        end
        $finish;
    end

endmodule
